>>> rtl/core/ptrm_pkg.sv
package ptrm_pkg;

   localparam int MaxTablesDefault = 32;
   localparam int EntriesPerTable = 1024;
   localparam int DirectoryEntries = 1024;
   localparam int PageShift = 12;
   localparam int DirShift = 22;
   localparam logic [31:0] LimitReset = 32'd134217728;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NO_FRAME = 2'd1;
   localparam logic [1:0] STATUS_NO_TABLE = 2'd2;

   localparam logic CSR_POOL_BASE = 1'b0;
   localparam logic CSR_POOL_LIMIT = 1'b1;

   // walk job handed from front to back
   typedef struct packed {
      logic        walk;
      logic        brk;
      logic [31:0] ret;
      logic [19:0] first_page;
      logic [20:0] end_page;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIR,
      ST_TAB,
      ST_NEXT,
      ST_DONE
   } walk_state_type;

endpackage

>>> rtl/core/page_table_range_mapper.sv
// One request at a time; a new request is taken only once the previous one's
// walk has ended, as set by the back-end walker, which reads directory then
// table memory for each page in turn.
// Reset is synchronous, active high; after it a clearing pass over all
// MAX_TABLES*1024 table entries blanks the stores before the first request is served.
module page_table_range_mapper #(
   parameter int MAX_TABLES = ptrm_pkg::MaxTablesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // address[31:0], length[59:32]
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // return_value[31:0], pages_mapped[47:32], status[49:48]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic              job_valid, job_ready;
   ptrm_pkg::job_type job;
   logic [31:0]       highest_break;
   logic [49:0]       rsp_bits;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {6'd0, rsp_bits};

   ptrm_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .highest_break(highest_break),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   ptrm_back #(.MAX_TABLES(MAX_TABLES)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid && !rsp_tvalid), .job_ready(job_ready), .job(job),
      .csr_tvalid(csr_valid), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .highest_break(highest_break),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_bits)
   );

endmodule

>>> rtl/core/ptrm_front.sv
module ptrm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,   // address[31:0], length[59:32]
   input  logic              req_tuser,   // mode
   input  logic [31:0]       highest_break,
   output logic              job_valid,
   input  logic              job_ready,
   output ptrm_pkg::job_type job
);

   logic              full_ff, full_in;
   ptrm_pkg::job_type job_ff, job_in;
   logic [31:0]       addr;
   logic [27:0]       len;
   logic [32:0]       end_addr;
   logic [31:0]       start;

   assign addr = req_tdata[31:0];
   assign len = req_tdata[59:32];
   assign req_tready = !full_ff;
   assign job_valid = full_ff;
   assign job = job_ff;

   always_comb begin
      start = req_tuser ? addr : highest_break;
      end_addr = req_tuser ? ({1'b0, addr} + {5'd0, len} + 33'hfff)
                           : ({1'b0, addr} + 33'hfff);
      job_in = job_ff;
      full_in = full_ff;
      if (full_ff && job_ready) begin
         full_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         full_in = 1'b1;
         job_in.brk = !req_tuser;
         job_in.ret = addr;
         job_in.walk = req_tuser || (addr != 32'd0 && addr > highest_break);
         job_in.first_page = start[31:12];
         job_in.end_page = end_addr[32] ? 21'h10_0000 : end_addr[32:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      job_ff <= job_in;
   end

endmodule

>>> rtl/core/ptrm_back.sv
module ptrm_back #(
   parameter int MAX_TABLES = ptrm_pkg::MaxTablesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  ptrm_pkg::job_type job,
   input  logic              csr_tvalid,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata,
   output logic [31:0]       highest_break,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [49:0]       rsp_tdata   // return_value, pages_mapped, status
);

   localparam int TW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
   localparam int SW = TW + 10;
   localparam int Slots = MAX_TABLES * ptrm_pkg::EntriesPerTable;

   logic [TW:0]  dir_mem [ptrm_pkg::DirectoryEntries];
   logic         tab_mem [Slots];
   logic [TW:0]  dir_rd_ff;
   logic         tab_rd_ff;

   ptrm_pkg::walk_state_type state_ff, state_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [20:0]   page_ff, page_in;
   logic [31:0]   frame_ff, frame_in;
   logic [31:0]   base_ff, base_in;
   logic [31:0]   limit_ff, limit_in;
   logic [10:0]   used_ff, used_in;
   logic [31:0]   cur_ff, cur_in;
   logic [31:0]   high_ff, high_in;
   logic [15:0]   count_ff, count_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   ret_ff, ret_in;
   logic [TW-1:0] tnum_ff, tnum_in;
   logic          out_ff, out_in;

   logic          dir_we, tab_we, dir_clr, tab_clr;
   logic [9:0]    dir_waddr;
   logic [TW:0]   dir_wdata;
   logic [SW-1:0] tab_addr;
   logic          tab_wdata;
   logic [32:0]   frame_end;

   assign highest_break = high_ff;
   assign rsp_tvalid = out_ff;
   assign rsp_tdata = {status_ff, count_ff, ret_ff};
   assign frame_end = {1'b0, frame_ff} + 33'h1000;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      page_in = page_ff;
      frame_in = frame_ff;
      base_in = base_ff;
      limit_in = limit_ff;
      used_in = used_ff;
      cur_in = cur_ff;
      high_in = high_ff;
      count_in = count_ff;
      status_in = status_ff;
      ret_in = ret_ff;
      tnum_in = tnum_ff;
      out_in = out_ff;
      job_ready = 1'b0;
      dir_we = 1'b0;
      tab_we = 1'b0;
      dir_clr = 1'b0;
      tab_clr = 1'b0;
      dir_waddr = page_ff[19:10];
      dir_wdata = {1'b1, used_ff[TW-1:0]};
      if (MAX_TABLES == 1) begin
         dir_wdata = {1'b1, 1'b0};
      end
      tab_addr = {tnum_ff, page_ff[9:0]};
      tab_wdata = 1'b1;
      if (out_ff && rsp_tready) begin
         out_in = 1'b0;
      end
      if (csr_tvalid) begin
         unique case (csr_index)
            ptrm_pkg::CSR_POOL_BASE: begin
               base_in = {csr_wdata[31:12], 12'd0};
               frame_in = {csr_wdata[31:12], 12'd0};
            end
            ptrm_pkg::CSR_POOL_LIMIT: limit_in = csr_wdata;
            default: ;
         endcase
      end
      unique case (state_ff)
         ptrm_pkg::ST_CLEAR: begin
            dir_clr = 1'b1;
            tab_clr = 1'b1;
            dir_waddr = clr_ff[9:0];
            dir_wdata = '0;
            tab_addr = clr_ff;
            tab_wdata = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SW'(Slots - 1)) begin
               state_in = ptrm_pkg::ST_IDLE;
            end
         end
         ptrm_pkg::ST_IDLE: begin
            if (job_valid && !out_ff) begin
               page_in = {1'b0, job.first_page};
               count_in = '0;
               status_in = ptrm_pkg::STATUS_OK;
               ret_in = job.ret;
               if (job.walk && {1'b0, job.first_page} < job.end_page) begin
                  state_in = ptrm_pkg::ST_DIR;
               end else begin
                  state_in = ptrm_pkg::ST_DONE;
               end
               if (job.brk && !job.walk) begin
                  if (job.ret != 32'd0) begin
                     cur_in = job.ret;
                  end
                  ret_in = (job.ret != 32'd0) ? job.ret : cur_ff;
                  state_in = ptrm_pkg::ST_DONE;
               end
            end
         end
         ptrm_pkg::ST_DIR: begin
            if (dir_rd_ff[TW]) begin
               tnum_in = dir_rd_ff[TW-1:0];
               state_in = ptrm_pkg::ST_TAB;
            end else if (used_ff >= 11'(MAX_TABLES)) begin
               status_in = ptrm_pkg::STATUS_NO_TABLE;
               state_in = ptrm_pkg::ST_DONE;
            end else begin
               dir_we = 1'b1;
               tnum_in = used_ff[TW-1:0];
               used_in = used_ff + 11'd1;
               state_in = ptrm_pkg::ST_NEXT;
            end
         end
         ptrm_pkg::ST_NEXT: begin
            state_in = ptrm_pkg::ST_TAB;
         end
         ptrm_pkg::ST_TAB: begin
            if (!tab_rd_ff) begin
               if (frame_end > {1'b0, limit_ff}) begin
                  status_in = ptrm_pkg::STATUS_NO_FRAME;
                  state_in = ptrm_pkg::ST_DONE;
               end else begin
                  tab_we = 1'b1;
                  frame_in = frame_end[31:0];
                  if (count_ff != 16'hffff) begin
                     count_in = count_ff + 16'd1;
                  end
               end
            end
            if (tab_rd_ff || frame_end <= {1'b0, limit_ff}) begin
               page_in = page_ff + 21'd1;
               if (page_ff + 21'd1 < job.end_page) begin
                  state_in = ptrm_pkg::ST_DIR;
               end else begin
                  state_in = ptrm_pkg::ST_DONE;
               end
            end
         end
         ptrm_pkg::ST_DONE: begin
            job_ready = 1'b1;
            out_in = 1'b1;
            state_in = ptrm_pkg::ST_IDLE;
            if (job.brk && job.walk) begin
               if (status_ff == ptrm_pkg::STATUS_OK) begin
                  high_in = job.ret;
                  cur_in = job.ret;
                  ret_in = job.ret;
               end else begin
                  ret_in = cur_ff;
               end
            end
         end
         default: state_in = ptrm_pkg::ST_IDLE;
      endcase
   end

   // job register stays stable until the walk ends: hold via front handshake
   always_ff @(posedge clock) begin
      if (dir_we || dir_clr) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_rd_ff <= dir_mem[page_in[19:10]];
   end

   always_ff @(posedge clock) begin
      if (tab_we || tab_clr) begin
         tab_mem[tab_addr] <= tab_wdata;
      end
      tab_rd_ff <= tab_mem[{tnum_in, page_in[9:0]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptrm_pkg::ST_CLEAR;
         clr_ff <= '0;
         base_ff <= '0;
         frame_ff <= '0;
         limit_ff <= ptrm_pkg::LimitReset;
         used_ff <= '0;
         cur_ff <= '0;
         high_ff <= '0;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         base_ff <= base_in;
         frame_ff <= frame_in;
         limit_ff <= limit_in;
         used_ff <= used_in;
         cur_ff <= cur_in;
         high_ff <= high_in;
         out_ff <= out_in;
      end
      page_ff <= page_in;
      count_ff <= count_in;
      status_ff <= status_in;
      ret_ff <= ret_in;
      tnum_ff <= tnum_in;
   end

endmodule
